// ----- rtl/lcc_pkg.sv -----
// ============================================================================
// lcc_pkg
// Shared types and constants for the level crossing controller: phase codes,
// register indexes, reset values and the bundles passed between modules.
// ============================================================================
package lcc_pkg;

    // Controller phase
    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_CLOSE = 2'd1,
        PH_OPEN  = 2'd2
    } lcc_phase_t;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OPEN_ANGLE  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLOSE_ANGLE = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_TICKS  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLINK_TICKS = 8'd3;

    // Register reset values
    localparam logic [7:0]  OPEN_ANGLE_RST  = 8'd0;
    localparam logic [7:0]  CLOSE_ANGLE_RST = 8'd90;
    localparam logic [15:0] STEP_TICKS_RST  = 16'd11;
    localparam logic [7:0]  BLINK_TICKS_RST = 8'd250;

    // Configuration bundle
    typedef struct packed {
        logic [7:0]  open_angle;
        logic [7:0]  close_angle;
        logic [15:0] step_ticks;
        logic [7:0]  blink_ticks;
    } lcc_cfg_t;

    // One result item
    typedef struct packed {
        logic [7:0] arm_angle;
        logic       lamp_a;
        logic       lamp_b;
        logic       indicator;
        lcc_phase_t phase;
    } lcc_result_t;

endpackage

// ----- rtl/level_crossing_controller_unit.sv -----
// ============================================================================
// level_crossing_controller_unit
// Level crossing controller: one timer tick per input transfer, one result
// transfer per tick with barrier angle, warning lamps, indicator and phase.
// ============================================================================
//
//  channel  | ports                                   | role
//  ---------+-----------------------------------------+---------------------
//  input    | s_valid s_ready s_track_one_busy        | one tick, track flags
//           | s_track_two_busy                        |
//  result   | m_valid m_ready m_arm_angle m_lamp_a    | state after the tick
//           | m_lamp_b m_indicator m_phase            |
//  config   | cfg_valid cfg_ready cfg_addr cfg_data   | register writes
//
//  One tick per cycle while the result port is not stalled; each tick passes
//  through the input register, then the controller logic into the result
//  register.
//  The controller state advances as a tick moves from the input register
//  into the result register, so a stalled result port holds back the state.
//  Reset (aresetn low, synchronous) loads register defaults and the waiting
//  phase with the barrier at the default open angle.
//
module level_crossing_controller_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_track_one_busy,
    input  logic                           s_track_two_busy,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_arm_angle,
    output logic                           m_lamp_a,
    output logic                           m_lamp_b,
    output logic                           m_indicator,
    output logic [1:0]                     m_phase,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data
);

    lcc_pkg::lcc_cfg_t    cfg;
    lcc_pkg::lcc_result_t result;

    logic                 in_valid_reg;
    logic                 in_busy_reg;
    logic                 out_valid_reg;
    lcc_pkg::lcc_result_t out_reg;
    logic                 out_free;
    logic                 advance;

    lcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: result slot free when empty or being taken
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_busy_reg <= s_track_one_busy || s_track_two_busy;
        end
    end

    lcc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .busy    (in_busy_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_arm_angle = out_reg.arm_angle;
    assign m_lamp_a    = out_reg.lamp_a;
    assign m_lamp_b    = out_reg.lamp_b;
    assign m_indicator = out_reg.indicator;
    assign m_phase     = out_reg.phase;

endmodule

// ----- rtl/lcc_cfg.sv -----
// ============================================================================
// lcc_cfg
// Configuration register file. Always ready; writes to unknown indexes are
// dropped.
// ============================================================================
module lcc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data,
    output lcc_pkg::lcc_cfg_t              cfg
);

    lcc_pkg::lcc_cfg_t cfg_reg;
    lcc_pkg::lcc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                lcc_pkg::CFG_OPEN_ANGLE:  cfg_next.open_angle  = cfg_data[7:0];
                lcc_pkg::CFG_CLOSE_ANGLE: cfg_next.close_angle = cfg_data[7:0];
                lcc_pkg::CFG_STEP_TICKS:  cfg_next.step_ticks  = cfg_data;
                lcc_pkg::CFG_BLINK_TICKS: cfg_next.blink_ticks = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_angle  <= lcc_pkg::OPEN_ANGLE_RST;
            cfg_reg.close_angle <= lcc_pkg::CLOSE_ANGLE_RST;
            cfg_reg.step_ticks  <= lcc_pkg::STEP_TICKS_RST;
            cfg_reg.blink_ticks <= lcc_pkg::BLINK_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/lcc_core.sv -----
// ============================================================================
// lcc_core
// Phase controller: countdowns, lamp blinking, barrier stepping and phase
// changes for one tick. State moves only when tick_en is high.
// ============================================================================
module lcc_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  logic                  busy,
    input  lcc_pkg::lcc_cfg_t     cfg,
    output lcc_pkg::lcc_result_t  result
);

    lcc_pkg::lcc_phase_t phase_reg, phase_next;
    logic                entry_reg, entry_next;
    logic [7:0]          angle_reg, angle_next;
    logic [7:0]          blink_reg, blink_next;
    logic [15:0]         step_reg, step_next;
    logic                lamp_a_reg, lamp_a_next;
    logic                lamp_b_reg, lamp_b_next;
    logic                ind_reg, ind_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= lcc_pkg::PH_WAIT;
            entry_reg  <= 1'b1;
            angle_reg  <= lcc_pkg::OPEN_ANGLE_RST;
            blink_reg  <= '0;
            step_reg   <= '0;
            lamp_a_reg <= 1'b0;
            lamp_b_reg <= 1'b0;
            ind_reg    <= 1'b0;
        end else if (tick_en) begin
            phase_reg  <= phase_next;
            entry_reg  <= entry_next;
            angle_reg  <= angle_next;
            blink_reg  <= blink_next;
            step_reg   <= step_next;
            lamp_a_reg <= lamp_a_next;
            lamp_b_reg <= lamp_b_next;
            ind_reg    <= ind_next;
        end
    end

    // Next state for one tick
    always_comb begin
        // countdowns saturate at zero
        blink_next  = (blink_reg != '0) ? blink_reg - 8'd1 : blink_reg;
        step_next   = (step_reg != '0) ? step_reg - 16'd1 : step_reg;
        phase_next  = phase_reg;
        entry_next  = 1'b0;
        angle_next  = angle_reg;
        lamp_a_next = lamp_a_reg;
        lamp_b_next = lamp_b_reg;
        ind_next    = ind_reg;

        unique case (phase_reg)
            lcc_pkg::PH_CLOSE: begin
                if (entry_reg) begin
                    ind_next = 1'b1;
                end
                if (blink_next == '0) begin
                    blink_next  = cfg.blink_ticks;
                    lamp_b_next = lamp_a_reg;
                    lamp_a_next = !lamp_a_reg;
                end
                // barrier rises toward the closed angle
                if (step_next == '0) begin
                    step_next = cfg.step_ticks;
                    if (angle_reg < cfg.close_angle) begin
                        angle_next = angle_reg + 8'd1;
                    end
                end
                if (!busy) begin
                    phase_next = lcc_pkg::PH_OPEN;
                    entry_next = 1'b1;
                end
            end
            lcc_pkg::PH_OPEN: begin
                if (blink_next == '0) begin
                    blink_next  = cfg.blink_ticks;
                    lamp_b_next = lamp_a_reg;
                    lamp_a_next = !lamp_a_reg;
                end
                // barrier falls toward the open angle
                if (step_next == '0) begin
                    step_next = cfg.step_ticks;
                    if (angle_reg > cfg.open_angle) begin
                        angle_next = angle_reg - 8'd1;
                    end
                end
                // phase ends once open, or when a train shows up again
                if (angle_next == cfg.open_angle || busy) begin
                    ind_next    = 1'b0;
                    lamp_a_next = 1'b0;
                    lamp_b_next = 1'b0;
                    entry_next  = 1'b1;
                    phase_next  = (angle_next == cfg.open_angle) ? lcc_pkg::PH_WAIT
                                                                 : lcc_pkg::PH_CLOSE;
                end
            end
            default: begin
                // waiting, and the unused code acts the same
                phase_next = lcc_pkg::PH_WAIT;
                if (busy) begin
                    phase_next = lcc_pkg::PH_CLOSE;
                    entry_next = 1'b1;
                end
            end
        endcase

        result.arm_angle = angle_next;
        result.lamp_a    = lamp_a_next;
        result.lamp_b    = lamp_b_next;
        result.indicator = ind_next;
        result.phase     = phase_next;
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Level crossing controller testbench
// Drives track-occupancy ticks and register writes with random idling on
// both channels, predicts every result tick from a cycle-free behavioral
// copy of the controller, and checks each result field by field.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic [lcc_pkg::CFG_ADDR_W-1:0] cfg_addr_t;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_PRINTED    = 100;
    localparam cfg_addr_t CFG_ADDR_TOP = '1;

    // Clock, reset and DUT ports
    logic                           aclk             = 1'b0;
    logic                           aresetn          = 1'b0;
    logic                           s_valid          = 1'b0;
    logic                           s_ready;
    logic                           s_track_one_busy = 1'b0;
    logic                           s_track_two_busy = 1'b0;
    logic                           m_valid;
    logic                           m_ready          = 1'b0;
    logic [7:0]                     m_arm_angle;
    logic                           m_lamp_a;
    logic                           m_lamp_b;
    logic                           m_indicator;
    logic [1:0]                     m_phase;
    logic                           cfg_valid        = 1'b0;
    logic                           cfg_ready;
    logic [lcc_pkg::CFG_ADDR_W-1:0] cfg_addr         = '0;
    logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data         = '0;

    // Idling control, in percent per item / per cycle
    int idle_pct  = 30;
    int stall_pct = 30;
    int ready_hold = 0;

    // Bookkeeping
    int error_count  = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    // Predicted controller state and registers
    lcc_pkg::lcc_cfg_t   regs;
    lcc_pkg::lcc_phase_t cur_phase;
    logic                entry_flag;
    logic [7:0]          arm_pos;
    logic [7:0]          blink_left;
    logic [15:0]         step_left;
    logic                lamp_a_on;
    logic                lamp_b_on;
    logic                ind_on;

    // Predicted result ticks, oldest first
    lcc_pkg::lcc_result_t crossing_q[$];

    level_crossing_controller_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_track_one_busy (s_track_one_busy),
        .s_track_two_busy (s_track_two_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_arm_angle      (m_arm_angle),
        .m_lamp_a         (m_lamp_a),
        .m_lamp_b         (m_lamp_b),
        .m_indicator      (m_indicator),
        .m_phase          (m_phase),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result port back-pressure: random stall bursts
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH result %0d %s: got %0d, want %0d",
                     results_seen, what, got, want);
        error_count++;
    endtask

    // Advance the predicted controller by one tick and queue its result
    function automatic void advance_crossing(input logic t1, input logic t2);
        logic                 busy;
        logic                 entering;
        logic                 blink_due;
        logic                 step_due;
        lcc_pkg::lcc_result_t res;
        busy = t1 | t2;
        if (blink_left != 8'd0) blink_left = blink_left - 8'd1;
        if (step_left != 16'd0) step_left = step_left - 16'd1;
        entering   = entry_flag;
        entry_flag = 1'b0;
        blink_due  = (blink_left == 8'd0);
        step_due   = (step_left == 16'd0);

        // lamps swap and the barrier steps only while closing or opening
        if (cur_phase == lcc_pkg::PH_CLOSE || cur_phase == lcc_pkg::PH_OPEN) begin
            if (blink_due) begin
                blink_left = regs.blink_ticks;
                lamp_a_on  = !lamp_a_on;
                lamp_b_on  = !lamp_a_on;
            end
            if (step_due) step_left = regs.step_ticks;
        end

        case (cur_phase)
            lcc_pkg::PH_CLOSE: begin
                if (entering) ind_on = 1'b1;
                if (step_due && arm_pos < regs.close_angle) arm_pos = arm_pos + 8'd1;
                if (!busy) begin
                    cur_phase  = lcc_pkg::PH_OPEN;
                    entry_flag = 1'b1;
                end
            end
            lcc_pkg::PH_OPEN: begin
                if (step_due && arm_pos > regs.open_angle) arm_pos = arm_pos - 8'd1;
                if (arm_pos == regs.open_angle || busy) begin
                    ind_on     = 1'b0;
                    lamp_a_on  = 1'b0;
                    lamp_b_on  = 1'b0;
                    cur_phase  = (arm_pos == regs.open_angle) ? lcc_pkg::PH_WAIT
                                                              : lcc_pkg::PH_CLOSE;
                    entry_flag = 1'b1;
                end
            end
            default: begin
                cur_phase = lcc_pkg::PH_WAIT;
                if (busy) begin
                    cur_phase  = lcc_pkg::PH_CLOSE;
                    entry_flag = 1'b1;
                end
            end
        endcase

        res.arm_angle = arm_pos;
        res.lamp_a    = lamp_a_on;
        res.lamp_b    = lamp_b_on;
        res.indicator = ind_on;
        res.phase     = cur_phase;
        crossing_q.push_back(res);
    endfunction

    // Send one tick; optional idle burst first, handshake sampled at negedge
    task automatic send_tick(input logic t1, input logic t2);
        bit taken;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_track_one_busy <= t1;
        s_track_two_busy <= t2;
        do begin
            @(negedge aclk);
            taken = (s_ready === 1'b1);
            @(posedge aclk);
        end while (!taken);
        advance_crossing(t1, t2);
    endtask

    // One register write; cfg_valid is left high for back-to-back writes
    task automatic write_reg(input logic [lcc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [lcc_pkg::CFG_DATA_W-1:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            taken = (cfg_ready === 1'b1);
            @(posedge aclk);
        end while (!taken);
        case (idx)
            lcc_pkg::CFG_OPEN_ANGLE:  regs.open_angle  = val[7:0];
            lcc_pkg::CFG_CLOSE_ANGLE: regs.close_angle = val[7:0];
            lcc_pkg::CFG_STEP_TICKS:  regs.step_ticks  = val;
            lcc_pkg::CFG_BLINK_TICKS: regs.blink_ticks = val[7:0];
            default: ;
        endcase
    endtask

    // Write all four registers; unused upper data bits carry noise
    task automatic configure_crossing(input logic [7:0] open_deg, input logic [7:0] close_deg,
                                      input logic [15:0] step_n, input logic [7:0] blink_n);
        write_reg(lcc_pkg::CFG_OPEN_ANGLE,  {8'($urandom), open_deg});
        write_reg(lcc_pkg::CFG_CLOSE_ANGLE, {8'($urandom), close_deg});
        write_reg(lcc_pkg::CFG_STEP_TICKS,  step_n);
        write_reg(lcc_pkg::CFG_BLINK_TICKS, {8'($urandom), blink_n});
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and let every predicted result come back
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (crossing_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Train passages with random content, plus some random noise
    task automatic run_traffic(input int n_items);
        int         sent;
        int         span;
        logic [1:0] flags;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                span = $urandom_range(1, 8);
                repeat (span) if (sent < n_items) begin
                    flags = 2'($urandom);
                    send_tick(flags[0], flags[1]);
                    sent++;
                end
            end else begin
                // occupied stretch, then a clear stretch of random length
                span = $urandom_range(1, 25);
                repeat (span) if (sent < n_items) begin
                    flags = 2'($urandom_range(1, 3));
                    send_tick(flags[0], flags[1]);
                    sent++;
                end
                span = $urandom_range(1, 60);
                repeat (span) if (sent < n_items) begin
                    send_tick(1'b0, 1'b0);
                    sent++;
                end
            end
        end
    endtask

    // Default registers: every track combination, enter and leave closing
    task automatic test_reset_tracks();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        wait_quiet();
    endtask

    // Zero reloads: lamps swap and barrier steps on every tick
    task automatic test_fast_reload();
        configure_crossing(8'd0, 8'd3, 16'd0, 8'd0);
        repeat (5) send_tick(1'b1, 1'b1);
        repeat (5) send_tick(1'b0, 1'b0);
        wait_quiet();
    endtask

    // Barrier on the far side of both targets, slowest reloads,
    // and writes to indexes past the last register
    task automatic test_far_side();
        write_reg(CFG_ADDR_TOP, 16'($urandom));
        write_reg(cfg_addr_t'($urandom_range(lcc_pkg::CFG_BLINK_TICKS + 1,
                                             CFG_ADDR_TOP - 1)),
                  16'($urandom));
        configure_crossing(8'd180, 8'd0, 16'hFFFF, 8'd255);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        wait_quiet();
    endtask

    // Several random register settings, each with a burst of traffic
    task automatic test_random_traffic();
        logic [7:0]  open_deg;
        logic [7:0]  close_deg;
        logic [15:0] step_n;
        logic [7:0]  blink_n;
        int          pick;
        for (int p = 0; p < 6; p++) begin
            idle_pct  = 15 * $urandom_range(0, 3);
            stall_pct = 15 * $urandom_range(0, 3);
            open_deg  = 8'($urandom_range(0, 30));
            close_deg = open_deg + 8'($urandom_range(0, 30));
            if (p == 1) begin
                // top of the angle range
                open_deg  = 8'd170;
                close_deg = 8'd180;
            end
            pick = $urandom_range(99);
            if (pick < 80)      step_n = 16'($urandom_range(0, 3));
            else if (pick < 90) step_n = 16'($urandom_range(4, 40));
            else                step_n = 16'($urandom);
            blink_n = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 6)) : 8'($urandom);
            configure_crossing(open_deg, close_deg, step_n, blink_n);
            run_traffic(105);
            wait_quiet();
        end
    endtask

    // Back-to-back ticks with no idling on either side
    task automatic test_steady_stream();
        logic [7:0] open_deg;
        idle_pct  = 0;
        stall_pct = 0;
        open_deg  = 8'($urandom_range(0, 20));
        configure_crossing(open_deg, open_deg + 8'($urandom_range(1, 20)),
                           16'($urandom_range(0, 2)), 8'($urandom_range(0, 4)));
        run_traffic(90);
        wait_quiet();
    endtask

    // Result checker: a transfer seen at negedge completes at the next edge
    always @(negedge aclk) begin : check_results
        lcc_pkg::lcc_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (crossing_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = crossing_q.pop_front();
                if (m_arm_angle !== want.arm_angle)
                    report_mismatch("arm_angle", m_arm_angle, want.arm_angle);
                if (m_lamp_a !== want.lamp_a)
                    report_mismatch("lamp_a", m_lamp_a, want.lamp_a);
                if (m_lamp_b !== want.lamp_b)
                    report_mismatch("lamp_b", m_lamp_b, want.lamp_b);
                if (m_indicator !== want.indicator)
                    report_mismatch("indicator", m_indicator, want.indicator);
                if (m_phase !== want.phase)
                    report_mismatch("phase", m_phase, want.phase);
            end
            results_seen++;
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(negedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)
                || (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        regs.open_angle  = lcc_pkg::OPEN_ANGLE_RST;
        regs.close_angle = lcc_pkg::CLOSE_ANGLE_RST;
        regs.step_ticks  = lcc_pkg::STEP_TICKS_RST;
        regs.blink_ticks = lcc_pkg::BLINK_TICKS_RST;
        cur_phase  = lcc_pkg::PH_WAIT;
        entry_flag = 1'b1;
        arm_pos    = lcc_pkg::OPEN_ANGLE_RST;
        blink_left = 8'd0;
        step_left  = 16'd0;
        lamp_a_on  = 1'b0;
        lamp_b_on  = 1'b0;
        ind_on     = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_tracks();
        test_fast_reload();
        test_far_side();
        test_random_traffic();
        test_steady_stream();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lcc_pkg.sv
rtl/lcc_cfg.sv
rtl/lcc_core.sv
rtl/level_crossing_controller_unit.sv
bench/testbench.sv
